FILE: sv/fsh_pkg.sv
// Shared types and constants for the frequency-sorted histogram core.
package fsh_pkg;

  localparam int VALUE_W       = 6;
  localparam int COUNT_W       = 11;
  localparam int VALUE_SPAN    = 64;
  localparam int COUNT_MAX     = 2047;
  localparam int NUM_BINS_DEF  = 64;
  localparam int MAX_ITEMS_DEF = 1024;

  // One value and its count as held in a sorter cell.
  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
  } item_t;

  // Control broadcast to every histogram cell.
  typedef struct packed {
    logic               load;
    logic [VALUE_W-1:0] value;
    logic               drain;
  } hist_ctl_t;

  // Control broadcast to every sorter cell.
  typedef struct packed {
    logic  insert;
    logic  pop;
    item_t item;
  } sort_ctl_t;

endpackage

FILE: sv/fsh_hist_cell.sv
// One histogram bin: counts matching values and shifts toward bin 0 on drain.
module fsh_hist_cell
  import fsh_pkg::*;
#(
  parameter int IDX         = 0,
  parameter int COUNT_LIMIT = MAX_ITEMS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  hist_ctl_t          ctl,
  input  logic [COUNT_W-1:0] right_count,
  output logic [COUNT_W-1:0] count
);

  localparam logic [COUNT_W-1:0] LIMIT = COUNT_W'(COUNT_LIMIT);
  localparam logic [VALUE_W-1:0] MY_VALUE = VALUE_W'(IDX);

  logic [COUNT_W-1:0] count_next;

  // Drain takes the neighbor's count; load adds one on a match until the limit.
  always_comb begin
    count_next = count;
    if (ctl.drain) begin
      count_next = right_count;
    end else if (ctl.load && ctl.value == MY_VALUE && count < LIMIT) begin
      count_next = count + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

FILE: sv/fsh_sort_cell.sv
// One sorter cell: keeps its item, takes the new one, or takes a neighbor's.
module fsh_sort_cell
  import fsh_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  sort_ctl_t ctl,
  input  item_t     left_item,
  input  logic      left_gt,
  input  item_t     right_item,
  output item_t     item,
  output logic      gt
);

  item_t item_next;

  // An empty cell or a strictly larger count yields to the new item, which
  // keeps equal counts in arrival order.
  assign gt = !item.valid || (item.count > ctl.item.count);

  always_comb begin
    item_next = item;
    if (ctl.pop) begin
      item_next = right_item;
    end else if (ctl.insert && gt) begin
      item_next = left_gt ? left_item : ctl.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else begin
      item.valid <= item_next.valid;
    end
    item.value <= item_next.value;
    item.count <= item_next.count;
  end

endmodule

FILE: sv/frequency_sort_histogram_core.sv
// Histogram cell row feeding a systolic insertion sorter, top level.
// Loading takes one item per cycle; the marked item is counted like the rest.
// After it, bins 0..top move into the sorter in turn (top = largest value
// seen), then the pairs leave one per cycle from sorter cell 0 as the sink allows.
// No input is taken from the marked item until the last pair is delivered.
// Reset (synchronous) clears all counts, the largest value and the sorter.
module frequency_sort_histogram_core
  import fsh_pkg::*;
#(
  parameter int NUM_BINS  = NUM_BINS_DEF,
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [5:0] value, [7:6] zero
  input  logic        s_tlast,   // last_item
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [5:0] out_value, [16:6] out_count, [23:17] zero
  output logic        m_tlast    // out_last
);

  localparam int USED_BINS   = (NUM_BINS < VALUE_SPAN) ? NUM_BINS : VALUE_SPAN;
  localparam int COUNT_LIMIT = (MAX_ITEMS < COUNT_MAX) ? MAX_ITEMS : COUNT_MAX;

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_SORT = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t             state, state_next;
  logic [VALUE_W-1:0] largest, largest_next;
  logic [VALUE_W-1:0] top, top_next;
  logic [VALUE_W-1:0] cnt, cnt_next;

  logic [VALUE_W-1:0] in_value;
  logic               in_ok;
  logic               in_take;
  logic               out_take;

  hist_ctl_t          hctl;
  sort_ctl_t          sctl;
  logic [COUNT_W-1:0] bin  [USED_BINS];
  item_t              slot [USED_BINS];
  logic               gt   [USED_BINS];

  assign in_value = s_tdata[VALUE_W-1:0];
  assign in_ok    = 32'(in_value) < USED_BINS;
  assign s_tready = (state == ST_LOAD);
  assign in_take  = s_tvalid && s_tready;
  assign out_take = m_tvalid && m_tready;

  // Histogram control: count on load, shift toward bin 0 while sorting.
  assign hctl.load  = in_take && in_ok;
  assign hctl.value = in_value;
  assign hctl.drain = (state == ST_SORT);

  // Sorter control: insert the bin leaving cell 0, pop on each delivered pair.
  assign sctl.insert     = (state == ST_SORT);
  assign sctl.pop        = (state == ST_EMIT) && out_take;
  assign sctl.item.valid = 1'b1;
  assign sctl.item.value = cnt;
  assign sctl.item.count = bin[0];

  // Sequencing of load, transfer into the sorter and emission.
  always_comb begin
    state_next   = state;
    largest_next = largest;
    top_next     = top;
    cnt_next     = cnt;
    case (state)
      ST_LOAD: begin
        if (in_take) begin
          if (in_ok && in_value > largest) begin
            largest_next = in_value;
          end
          if (s_tlast) begin
            top_next     = largest_next;
            largest_next = '0;
            cnt_next     = '0;
            state_next   = ST_SORT;
          end
        end
      end
      ST_SORT: begin
        cnt_next = cnt + VALUE_W'(1);
        if (cnt == top) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_take && m_tlast) begin
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      largest <= '0;
      cnt     <= '0;
    end else begin
      state   <= state_next;
      largest <= largest_next;
      cnt     <= cnt_next;
    end
    top <= top_next;
  end

  // Row of histogram bins and row of sorter cells.
  for (genvar i = 0; i < USED_BINS; i++) begin : g_cells
    logic [COUNT_W-1:0] right_count;
    item_t              left_item;
    logic               left_gt;
    item_t              right_item;

    if (i == USED_BINS - 1) begin : g_end
      assign right_count = '0;
      assign right_item  = '0;
    end else begin : g_mid
      assign right_count = bin[i+1];
      assign right_item  = slot[i+1];
    end

    if (i == 0) begin : g_head
      assign left_item = '0;
      assign left_gt   = 1'b0;
    end else begin : g_body
      assign left_item = slot[i-1];
      assign left_gt   = gt[i-1];
    end

    fsh_hist_cell #(
      .IDX         (i),
      .COUNT_LIMIT (COUNT_LIMIT)
    ) u_hist (
      .clk         (clk),
      .rst         (rst),
      .ctl         (hctl),
      .right_count (right_count),
      .count       (bin[i])
    );

    fsh_sort_cell u_sort (
      .clk        (clk),
      .rst        (rst),
      .ctl        (sctl),
      .left_item  (left_item),
      .left_gt    (left_gt),
      .right_item (right_item),
      .item       (slot[i]),
      .gt         (gt[i])
    );
  end

  // Results leave from the head cell; the pair is last when the next cell is empty.
  assign m_tvalid = (state == ST_EMIT) && slot[0].valid;
  assign m_tdata  = {7'b0, slot[0].count, slot[0].value};
  assign m_tlast  = !slot[1].valid;

  // Input and output never open together.
  assert property (@(posedge clk) disable iff (rst) m_tvalid |-> !s_tready)
    else $error("input ready while results are pending");

  // Delivering the last pair returns the block to loading.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready)
    else $error("block did not return to loading after the last pair");

  // The transfer counter never passes the top bin.
  assert property (@(posedge clk) disable iff (rst) (state == ST_SORT) |-> (cnt <= top))
    else $error("transfer counter ran past the top bin");

  // Once the transfer finishes, the first result is ready at once.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SORT && cnt == top) |=> m_tvalid)
    else $error("no result after the transfer into the sorter");

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the frequency-sorted histogram core.
module tb_top;
  import fsh_pkg::*;

  localparam int NUM_BINS    = NUM_BINS_DEF;
  localparam int MAX_ITEMS   = MAX_ITEMS_DEF;
  localparam int USED_BINS   = (NUM_BINS < VALUE_SPAN) ? NUM_BINS : VALUE_SPAN;
  localparam int COUNT_LIMIT = (MAX_ITEMS < COUNT_MAX) ? MAX_ITEMS : COUNT_MAX;
  localparam int CYCLE_LIMIT = 5000000;
  localparam int TAIL_CYCLES = 200;

  // One input request as queued for the driver.
  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               mark;
    int                 gap;
    bit                 hold;
  } value_req_t;

  // One expected value/count pair.
  typedef struct {
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
    logic               last;
  } pair_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [5:0] value, [7:6] zero
  logic        s_tlast;   // last_item
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // [5:0] out_value, [16:6] out_count, [23:17] zero
  logic        m_tlast;   // out_last

  value_req_t         pending_q[$];
  pair_t              expected_pairs_q[$];
  logic [COUNT_W-1:0] hist_bins [0:VALUE_SPAN-1];
  int                 hist_top;
  int                 errors;
  int                 cycles;
  bit                 in_taken;
  int                 idle_cnt;
  int                 rx_stall_left;
  int                 rx_phase_left;
  bit                 rx_calm;

  frequency_sort_histogram_core #(
    .NUM_BINS (NUM_BINS),
    .MAX_ITEMS(MAX_ITEMS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  // Clock, reset and known start values on every input.
  initial begin
    clk      = 1'b0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    m_tready = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Counts one value; on the marked item, lists the bins in stable count order.
  task automatic count_value(input logic [VALUE_W-1:0] v, input logic mark);
    bit    taken [0:VALUE_SPAN-1];
    int    top;
    int    best;
    pair_t p;
    if (v < USED_BINS) begin
      if (hist_bins[v] < COUNT_LIMIT) hist_bins[v] = hist_bins[v] + 1'b1;
      if (v > hist_top) hist_top = v;
    end
    if (mark) begin
      top = (hist_top < USED_BINS) ? hist_top : USED_BINS - 1;
      for (int c = 0; c < VALUE_SPAN; c++) taken[c] = 1'b0;
      // Smallest count first; the strict compare keeps the lower value on ties.
      for (int k = 0; k <= top; k++) begin
        best = -1;
        for (int c = 0; c <= top; c++) begin
          if (!taken[c] && (best < 0 || hist_bins[c] < hist_bins[best])) best = c;
        end
        taken[best] = 1'b1;
        p.value = best[VALUE_W-1:0];
        p.count = hist_bins[best];
        p.last  = (k == top);
        expected_pairs_q.push_back(p);
      end
      for (int c = 0; c < VALUE_SPAN; c++) hist_bins[c] = '0;
      hist_top = 0;
    end
  endtask

  task automatic add_item(input int v, input bit mark, input int gap, input bit hold);
    value_req_t r;
    r.value = v[VALUE_W-1:0];
    r.mark  = mark;
    r.gap   = gap;
    r.hold  = hold;
    pending_q.push_back(r);
  endtask

  // Input driver: changes at the falling edge, holds a request until taken.
  always @(negedge clk) begin
    if (!rst) begin
      if (s_tvalid && !in_taken) begin
        // Request still waiting for tready.
      end else if (pending_q.size() != 0 && idle_cnt >= pending_q[0].gap &&
                   !(pending_q[0].hold && expected_pairs_q.size() != 0)) begin
        s_tdata  <= {2'b00, pending_q[0].value};
        s_tlast  <= pending_q[0].mark;
        s_tvalid <= 1'b1;
        idle_cnt <= 0;
        void'(pending_q.pop_front());
      end else begin
        s_tvalid <= 1'b0;
        idle_cnt <= idle_cnt + 1;
      end
    end
  end

  // Output ready: random stalls, with calm phases of no stalls at all.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (rx_phase_left == 0) begin
        rx_calm       <= ($urandom_range(0, 3) == 0);
        rx_phase_left <= $urandom_range(50, 300);
      end else begin
        rx_phase_left <= rx_phase_left - 1;
      end
      if (rx_stall_left > 0) begin
        rx_stall_left <= rx_stall_left - 1;
        m_tready      <= 1'b0;
      end else begin
        m_tready      <= 1'b1;
        rx_stall_left <= pick_gap(rx_calm);
      end
    end
  end

  // Monitor: predicts on accepted inputs and checks accepted pairs.
  always @(posedge clk) begin
    pair_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else if (!rst) begin
      in_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) count_value(s_tdata[VALUE_W-1:0], s_tlast);
      if (m_tvalid && m_tready) begin
        if (expected_pairs_q.size() == 0) begin
          errors <= errors + 1;
          $display("%0t: unexpected pair value=%0d count=%0d last=%0b", $time,
                   m_tdata[5:0], m_tdata[16:6], m_tlast);
        end else begin
          e = expected_pairs_q.pop_front();
          if (m_tdata[5:0] !== e.value || m_tdata[16:6] !== e.count || m_tlast !== e.last)
          begin
            errors <= errors + 1;
            $display({"%0t: mismatch expected value=%0d count=%0d last=%0b,",
                      " got value=%0d count=%0d last=%0b"},
                     $time, e.value, e.count, e.last, m_tdata[5:0], m_tdata[16:6], m_tlast);
          end
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int  rand_items;
    int  n;
    int  hi;
    int  sets;
    bit  calm;
    errors        = 0;
    cycles        = 0;
    in_taken      = 1'b0;
    idle_cnt      = 0;
    rx_stall_left = 0;
    rx_phase_left = 0;
    rx_calm       = 1'b0;
    hist_top      = 0;
    for (int c = 0; c < VALUE_SPAN; c++) hist_bins[c] = '0;

    // Directed: single smallest value, then single largest value (full list).
    add_item(0, 1'b1, 0, 1'b0);
    add_item(63, 1'b1, 2, 1'b1);
    // Ties must keep ascending value order.
    add_item(2, 1'b0, 0, 1'b1);
    add_item(2, 1'b0, 0, 1'b0);
    add_item(0, 1'b0, 1, 1'b0);
    add_item(1, 1'b0, 0, 1'b0);
    add_item(1, 1'b0, 0, 1'b0);
    add_item(3, 1'b1, 0, 1'b0);
    // Counts falling with value from 3 to 5, so those values come out reversed.
    add_item(5, 1'b0, 0, 1'b0);
    add_item(4, 1'b0, 0, 1'b0);
    add_item(4, 1'b0, 0, 1'b0);
    add_item(3, 1'b0, 0, 1'b0);
    add_item(3, 1'b0, 0, 1'b0);
    add_item(3, 1'b1, 0, 1'b0);
    // Largest value arrives first and must still set the list length.
    add_item(63, 1'b0, 0, 1'b0);
    add_item(0, 1'b1, 0, 1'b0);

    // Random sets, mostly short, with varied value ranges and repeats.
    rand_items = 0;
    sets       = 0;
    while (rand_items < 355) begin
      n    = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      hi   = ($urandom_range(0, 3) == 0) ? 63 : $urandom_range(0, 63);
      calm = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < n; k++) begin
        add_item($urandom_range(0, hi), k == n - 1, pick_gap(calm),
                 (k == 0) && (sets % 8 == 7));
      end
      rand_items += n;
      sets++;
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_q.size() != 0 || s_tvalid || expected_pairs_q.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0 && expected_pairs_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

FILE: frequency_sort_histogram_core.f
sv/fsh_pkg.sv
sv/fsh_hist_cell.sv
sv/fsh_sort_cell.sv
sv/frequency_sort_histogram_core.sv
test/tb_top.sv
